[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 32;

  localparam logic [1:0] CMD_REG   = 2'd0;
  localparam logic [1:0] CMD_UNREG = 2'd1;
  localparam logic [1:0] CMD_FEED  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] client_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       kick;
  } out_item_t;

endpackage

[hdl/task_checkin_watchdog.sv]
// Check-in table in front of a hardware watchdog.
// Input channel (in_valid / in_stall / in_data) carries one command item:
// register, unregister or feed for a client id. Each item yields exactly one
// result item on the output channel (out_valid / out_stall / out_data) with a
// status code and a kick bit that pulses the watchdog.
// cfg_we / cfg_wdata write the enable bit; write it only while the block is
// idle. Feeds still get a status but neither check in nor kick while it is clear.
// Each item walks the client id memory one slot per cycle through its single
// read port: the block accepts the item, issues a read for every slot, takes
// the last read data and then updates the table, writing the result into the
// output register; the next item is taken in the cycle after that update.
// A result waits in the output register while the receiver stalls; the next
// item is accepted and scanned meanwhile, and holds before its table update
// until the output register is free.
// Reset (synchronous, rst_n low) empties the table, clears all check-in marks
// and the enable bit; the id memory itself needs no clearing.
`timescale 1ns / 1ps

module task_checkin_watchdog import tcw_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic               enabled_r, enabled_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;
  logic               res_ready;
  logic               res_valid;
  out_item_t          res_data;

  tcw_mem #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  tcw_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enabled   (enabled_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    enabled_nxt   = cfg_we ? cfg_wdata : enabled_r;
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enabled_r   <= enabled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is still in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a stalled output item");

  a_kick_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kick) |->
      (out_data.status == ST_OK || out_data.status == ST_NOTFOUND))
    else $error("kick with a rejected command");

  a_kick_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_data.kick) |-> enabled_r)
    else $error("kick while disabled");
`endif

endmodule

[hdl/tcw_mem.sv]
`timescale 1ns / 1ps

module tcw_mem import tcw_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ID_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enabled,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_stall,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [ID_BITS-1:0] mem_wdata,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [ID_BITS-1:0] mem_rdata,
  input  logic               res_ready,
  output logic               res_valid,
  output out_item_t          res_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_FIN} state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   freeidx_r, freeidx_nxt;
  logic               unchk_r, unchk_nxt;
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [SLOTS-1:0]   chk_r, chk_nxt;
  logic               hit;
  logic               slot_used;

  assign in_stall  = (state_r != S_IDLE);
  assign mem_raddr = idx_r;
  assign mem_waddr = freeidx_r;
  assign mem_wdata = key_r;
  assign slot_used = used_r[rd_idx_r];
  assign hit       = rd_vld_r && slot_used && (mem_rdata == key_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    rd_vld_nxt  = rd_vld_r;
    rd_idx_nxt  = rd_idx_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    found_nxt   = found_r;
    fidx_nxt    = fidx_r;
    free_nxt    = free_r;
    freeidx_nxt = freeidx_r;
    unchk_nxt   = unchk_r;
    used_nxt    = used_r;
    chk_nxt     = chk_r;
    mem_we      = 1'b0;
    res_valid   = 1'b0;
    res_data    = '{status: ST_OK, kick: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          key_nxt    = ID_BITS'(in_data.client_id);
          found_nxt  = 1'b0;
          free_nxt   = 1'b0;
          unchk_nxt  = 1'b0;
          idx_nxt    = '0;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_LAST: begin
        rd_vld_nxt = 1'b0;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the item
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_REG: begin
              if (found_r) begin
                res_data.status = ST_DUP;
              end else if (!free_r) begin
                res_data.status = ST_FULL;
              end else begin
                mem_we              = 1'b1;
                used_nxt[freeidx_r] = 1'b1;
                if (enabled && !unchk_r) begin
                  chk_nxt       = '0;
                  res_data.kick = 1'b1;
                end else begin
                  chk_nxt[freeidx_r] = enabled;
                end
              end
            end
            CMD_UNREG: begin
              if (!found_r) begin
                res_data.status = ST_NOTFOUND;
              end else begin
                used_nxt[fidx_r] = 1'b0;
                chk_nxt[fidx_r]  = 1'b0;
              end
            end
            CMD_FEED: begin
              if (!found_r) begin
                res_data.status = ST_NOTFOUND;
              end
              if (enabled) begin
                if (!unchk_r) begin
                  chk_nxt       = '0;
                  res_data.kick = 1'b1;
                end else if (found_r) begin
                  chk_nxt[fidx_r] = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // one slot's id returns per cycle: note match, lowest free slot, and
    // any other occupied slot still waiting to check in
    if (rd_vld_r) begin
      if (hit && !found_r) begin
        found_nxt = 1'b1;
        fidx_nxt  = rd_idx_r;
      end
      if (!slot_used && !free_r) begin
        free_nxt    = 1'b1;
        freeidx_nxt = rd_idx_r;
      end
      if (slot_used && !chk_r[rd_idx_r] && !hit) begin
        unchk_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      used_r   <= '0;
      chk_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      used_r   <= used_nxt;
      chk_r    <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    found_r   <= found_nxt;
    fidx_r    <= fidx_nxt;
    free_r    <= free_nxt;
    freeidx_r <= freeidx_nxt;
    unchk_r   <= unchk_nxt;
  end

endmodule
